// File: sv/lrt_pkg.sv
// ----------------------------------------------------------------------------
// Lock reference tracker package
// Sizes, request and result types, codes and controller states shared by the
// lock reference tracker files.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_ABORT  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [HANDLE_BITS-1:0] lock_id;
  } request_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   released_valid;
    logic [HANDLE_BITS-1:0] released_id;
    logic [CNT_W-1:0]       held_count;
    logic                   last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_REM_SCAN,
    ST_DROP,
    ST_ABORT
  } state_t;

endpackage

`default_nettype wire

// File: sv/lrt_slot_ram.sv
// ----------------------------------------------------------------------------
// Lock reference tracker slot memory
// One write port and one read port with registered read data, holding the
// lock handle of each slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_slot_ram (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [lrt_pkg::SLOT_W-1:0]      waddr,
  input  wire logic [lrt_pkg::HANDLE_BITS-1:0] wdata,
  input  wire logic [lrt_pkg::SLOT_W-1:0]      raddr,
  output logic      [lrt_pkg::HANDLE_BITS-1:0] rdata
);

  logic [lrt_pkg::HANDLE_BITS-1:0] mem [lrt_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/lock_reference_tracker_top.sv
// ----------------------------------------------------------------------------
// Lock reference tracker
// Slot table of held lock handles with add, remove and abort requests.
// ----------------------------------------------------------------------------
// A request (mode, lock_id) is taken at a rising edge with start high and
// busy low. Each result is shown on result for one cycle with result_strobe
// high; the receiver cannot stall it, so results are never held back.
// Add on a table without holes, add on a full table, remove or abort on an
// empty table and the unused mode show their result in the next cycle
// without raising busy. Add into a hole scans the used bits downward from
// the top, one slot a cycle, and shows its result the cycle after the hole
// is found. Remove reads the handle memory downward from the top, one slot a
// cycle, and compares each handle as its registered read data returns.
// Removing the top slot then lowers the top past each empty slot below it,
// one slot a cycle. Abort reads slots upward from slot zero, one a cycle,
// and shows a result for each used slot, so empty slots leave gaps. The
// longest request is a removal of the top slot with every slot below it
// empty. Busy falls in the cycle that shows the last result.
// Reset clears the used bits, the top mark and the held count at once; the
// handle memory needs no clearing since handles of unused slots are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_reference_tracker_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire lrt_pkg::request_t request,
  output lrt_pkg::result_t      result,
  output logic                  result_strobe
);

  lrt_pkg::state_t state, state_next;

  logic [lrt_pkg::SLOTS-1:0]       used, used_next;
  logic [lrt_pkg::CNT_W-1:0]       top, top_next;
  logic [lrt_pkg::CNT_W-1:0]       held, held_next;
  logic [lrt_pkg::SLOT_W-1:0]      idx, idx_next;
  logic                            scan_end, scan_end_next;
  logic                            pend, pend_next;
  logic [lrt_pkg::SLOT_W-1:0]      pend_idx, pend_idx_next;
  logic [lrt_pkg::HANDLE_BITS-1:0] id_reg, id_reg_next;
  lrt_pkg::result_t                result_next;
  logic                            result_strobe_next;

  logic                            we;
  logic [lrt_pkg::SLOT_W-1:0]      waddr;
  logic [lrt_pkg::HANDLE_BITS-1:0] wdata;
  logic [lrt_pkg::SLOT_W-1:0]      raddr;
  logic [lrt_pkg::HANDLE_BITS-1:0] rdata;

  logic [lrt_pkg::CNT_W-1:0]       top_dec;
  logic [lrt_pkg::SLOT_W-1:0]      top_last;

  assign top_dec  = top - lrt_pkg::CNT_W'(1);
  assign top_last = top_dec[lrt_pkg::SLOT_W-1:0];
  assign busy     = (state != lrt_pkg::ST_IDLE);

  lrt_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lrt_pkg::ST_IDLE;
      used          <= '0;
      top           <= '0;
      held          <= '0;
      scan_end      <= 1'b0;
      pend          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      used          <= used_next;
      top           <= top_next;
      held          <= held_next;
      scan_end      <= scan_end_next;
      pend          <= pend_next;
      result_strobe <= result_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    id_reg   <= id_reg_next;
    result   <= result_next;
  end

  always_comb begin
    state_next         = state;
    used_next          = used;
    top_next           = top;
    held_next          = held;
    idx_next           = idx;
    scan_end_next      = scan_end;
    pend_next          = 1'b0;
    pend_idx_next      = pend_idx;
    id_reg_next        = id_reg;
    result_next        = result;
    result_strobe_next = 1'b0;
    we                 = 1'b0;
    waddr              = idx;
    wdata              = id_reg;
    raddr              = idx;

    case (state)
      lrt_pkg::ST_IDLE: begin
        if (start) begin
          id_reg_next               = request.lock_id;
          scan_end_next             = 1'b0;
          result_next.status        = lrt_pkg::STATUS_OK;
          result_next.released_valid = 1'b0;
          result_next.released_id   = '0;
          result_next.held_count    = held;
          result_next.last          = 1'b1;
          case (request.mode)
            lrt_pkg::MODE_ADD: begin
              if (held == lrt_pkg::CNT_W'(lrt_pkg::SLOTS)) begin
                result_next.status = lrt_pkg::STATUS_FULL;
                result_strobe_next = 1'b1;
              end else if (held == top) begin
                we                     = 1'b1;
                waddr                  = top[lrt_pkg::SLOT_W-1:0];
                wdata                  = request.lock_id;
                used_next[top[lrt_pkg::SLOT_W-1:0]] = 1'b1;
                top_next               = top + lrt_pkg::CNT_W'(1);
                held_next              = held + lrt_pkg::CNT_W'(1);
                result_next.held_count = held + lrt_pkg::CNT_W'(1);
                result_strobe_next     = 1'b1;
              end else begin
                idx_next   = top_last;
                state_next = lrt_pkg::ST_ADD_SCAN;
              end
            end
            lrt_pkg::MODE_REMOVE: begin
              if (top == '0) begin
                result_next.status = lrt_pkg::STATUS_NOT_FOUND;
                result_strobe_next = 1'b1;
              end else begin
                idx_next   = top_last;
                state_next = lrt_pkg::ST_REM_SCAN;
              end
            end
            lrt_pkg::MODE_ABORT: begin
              if (top == '0) begin
                result_next.held_count = '0;
                result_strobe_next     = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = lrt_pkg::ST_ABORT;
              end
            end
            default: begin
              result_strobe_next = 1'b1;
            end
          endcase
        end
      end

      lrt_pkg::ST_ADD_SCAN: begin
        if (!used[idx]) begin
          we                     = 1'b1;
          waddr                  = idx;
          wdata                  = id_reg;
          used_next[idx]         = 1'b1;
          held_next              = held + lrt_pkg::CNT_W'(1);
          result_next.held_count = held + lrt_pkg::CNT_W'(1);
          result_strobe_next     = 1'b1;
          state_next             = lrt_pkg::ST_IDLE;
        end else begin
          idx_next = idx - lrt_pkg::SLOT_W'(1);
        end
      end

      lrt_pkg::ST_REM_SCAN: begin
        raddr = idx;
        if (!scan_end) begin
          pend_next     = 1'b1;
          pend_idx_next = idx;
          idx_next      = idx - lrt_pkg::SLOT_W'(1);
          scan_end_next = (idx == '0);
        end
        if (pend && used[pend_idx] && (rdata == id_reg)) begin
          pend_next           = 1'b0;
          used_next[pend_idx] = 1'b0;
          held_next           = held - lrt_pkg::CNT_W'(1);
          if (pend_idx == top_last) begin
            top_next   = top_dec;
            state_next = lrt_pkg::ST_DROP;
          end else begin
            result_next.held_count = held - lrt_pkg::CNT_W'(1);
            result_strobe_next     = 1'b1;
            state_next             = lrt_pkg::ST_IDLE;
          end
        end else if (pend && (pend_idx == '0)) begin
          pend_next          = 1'b0;
          result_next.status = lrt_pkg::STATUS_NOT_FOUND;
          result_strobe_next = 1'b1;
          state_next         = lrt_pkg::ST_IDLE;
        end
      end

      lrt_pkg::ST_DROP: begin
        if ((top != '0) && !used[top_last]) begin
          top_next = top_dec;
        end else begin
          result_next.held_count = held;
          result_strobe_next     = 1'b1;
          state_next             = lrt_pkg::ST_IDLE;
        end
      end

      lrt_pkg::ST_ABORT: begin
        raddr = idx;
        if (!scan_end) begin
          pend_next     = used[idx];
          pend_idx_next = idx;
          idx_next      = idx + lrt_pkg::SLOT_W'(1);
          scan_end_next = (idx == top_last);
        end
        if (pend) begin
          result_next.status         = lrt_pkg::STATUS_OK;
          result_next.released_valid = 1'b1;
          result_next.released_id    = rdata;
          result_next.held_count     = '0;
          result_next.last           = (pend_idx == top_last);
          result_strobe_next         = 1'b1;
          if (pend_idx == top_last) begin
            pend_next  = 1'b0;
            used_next  = '0;
            top_next   = '0;
            held_next  = '0;
            state_next = lrt_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = lrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/sv/lock_reference_tracker_top_test.sv
// ----------------------------------------------------------------------------
// Lock reference tracker testbench
// Drives add, remove, abort and unused-mode requests through the start/busy
// handshake, first from a directed table and then at random. Each result is
// checked field by field against a predicted slot table. The sender works in
// bursts with random gaps and drains the block completely at times.
// ----------------------------------------------------------------------------
module lock_reference_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 350;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } step_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  result_t  result;
  logic     result_strobe;

  lock_reference_tracker_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result        (result),
    .result_strobe (result_strobe)
  );

  always #6 clk = ~clk;

  logic [HANDLE_BITS-1:0] slot_handle_copy [SLOTS];
  bit                     slot_taken [SLOTS];
  int                     top_mark;
  int                     held_total;
  result_t                expected_results [$];
  step_t                  directed_steps [$];
  result_t                oldest;
  int                     mismatches;
  int                     results_seen;
  int                     releases_seen;
  int                     full_seen;
  int                     missing_seen;
  int                     requests_sent;
  int                     burst_left;

  function automatic logic [HANDLE_BITS-1:0] table_handle(input int k);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return 32'h8000_0001 ^ (32'h1 << k);
  endfunction

  task automatic track_request(input request_t r);
    result_t res;
    result_t prev;
    int      i;
    int      n;
    bit      done;
    res = '0;
    res.last = 1'b1;
    prev = '0;
    n = 0;
    done = 1'b0;
    case (r.mode)
      MODE_ADD: begin
        if (held_total >= SLOTS) begin
          res.status = STATUS_FULL;
        end else if (held_total == top_mark) begin
          slot_handle_copy[top_mark] = r.lock_id;
          slot_taken[top_mark] = 1'b1;
          top_mark++;
          held_total++;
        end else begin
          for (i = top_mark - 1; i >= 0 && !done; i--) begin
            if (!slot_taken[i]) begin
              slot_handle_copy[i] = r.lock_id;
              slot_taken[i] = 1'b1;
              held_total++;
              done = 1'b1;
            end
          end
          if (!done) res.status = STATUS_FULL;
        end
        res.held_count = CNT_W'(held_total);
        expected_results.push_back(res);
      end
      MODE_REMOVE: begin
        if (top_mark == 0) begin
          res.status = STATUS_NOT_FOUND;
        end else if (slot_taken[top_mark-1] && slot_handle_copy[top_mark-1] == r.lock_id) begin
          slot_taken[top_mark-1] = 1'b0;
          top_mark--;
          while (top_mark > 0 && !slot_taken[top_mark-1]) top_mark--;
          held_total--;
        end else begin
          for (i = top_mark - 1; i >= 0 && !done; i--) begin
            if (slot_taken[i] && slot_handle_copy[i] == r.lock_id) begin
              slot_taken[i] = 1'b0;
              held_total--;
              done = 1'b1;
            end
          end
          if (!done) res.status = STATUS_NOT_FOUND;
        end
        res.held_count = CNT_W'(held_total);
        expected_results.push_back(res);
      end
      MODE_ABORT: begin
        for (i = 0; i < top_mark; i++) begin
          if (slot_taken[i]) begin
            if (n > 0) expected_results.push_back(prev);
            prev = '0;
            prev.released_valid = 1'b1;
            prev.released_id = slot_handle_copy[i];
            slot_taken[i] = 1'b0;
            n++;
          end
        end
        top_mark = 0;
        held_total = 0;
        if (n == 0) begin
          expected_results.push_back(res);
        end else begin
          prev.last = 1'b1;
          expected_results.push_back(prev);
        end
      end
      default: begin
        res.held_count = CNT_W'(held_total);
        expected_results.push_back(res);
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: %p", result);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", oldest.status, result.status);
        check_field("released_valid", oldest.released_valid, result.released_valid);
        check_field("released_id", oldest.released_id, result.released_id);
        check_field("held_count", oldest.held_count, result.held_count);
        check_field("last", oldest.last, result.last);
        results_seen++;
        if (oldest.released_valid) releases_seen++;
        if (oldest.status == STATUS_FULL) full_seen++;
        if (oldest.status == STATUS_NOT_FOUND) missing_seen++;
      end
    end
  end

  task automatic add_step(input logic [1:0] m, input logic [HANDLE_BITS-1:0] id,
                          input bit typed, input logic [1:0] st, input int cnt);
    step_t s;
    s.req.mode = m;
    s.req.lock_id = id;
    s.typed = typed;
    s.want = '0;
    s.want.status = st;
    s.want.held_count = CNT_W'(cnt);
    s.want.last = 1'b1;
    directed_steps.push_back(s);
  endtask

  task automatic send(input request_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
    track_request(r);
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic random_request(input bit filling, output request_t r);
    int pick;
    int held_idx [$];
    int i;
    for (i = 0; i < SLOTS; i++) if (slot_taken[i]) held_idx.push_back(i);
    pick = $urandom_range(0, 99);
    r.lock_id = $urandom;
    if (pick < (filling ? 60 : 30)) begin
      r.mode = MODE_ADD;
      if (held_idx.size() > 0 && $urandom_range(0, 4) == 0)
        r.lock_id = slot_handle_copy[held_idx[$urandom_range(0, held_idx.size() - 1)]];
    end else if (pick < 90) begin
      r.mode = MODE_REMOVE;
      if (held_idx.size() > 0 && $urandom_range(0, 4) != 0)
        r.lock_id = slot_handle_copy[held_idx[$urandom_range(0, held_idx.size() - 1)]];
    end else if (pick < 96) begin
      r.mode = MODE_ABORT;
    end else begin
      r.mode = MODE_UNUSED;
    end
  endtask

  initial begin
    request_t r;
    int       k;
    int       counted;
    int       issued;
    bit       filling;

    add_step(MODE_ABORT, '0, 1'b1, STATUS_OK, 0);
    add_step(MODE_REMOVE, '0, 1'b1, STATUS_NOT_FOUND, 0);
    add_step(MODE_UNUSED, '1, 1'b1, STATUS_OK, 0);
    for (k = 0; k < SLOTS; k++) add_step(MODE_ADD, table_handle(k), 1'b1, STATUS_OK, k + 1);
    add_step(MODE_ADD, 32'h1234_5678, 1'b1, STATUS_FULL, SLOTS);
    add_step(MODE_REMOVE, table_handle(5), 1'b0, STATUS_OK, 0);
    add_step(MODE_REMOVE, table_handle(14), 1'b0, STATUS_OK, 0);
    add_step(MODE_REMOVE, table_handle(15), 1'b0, STATUS_OK, 0);
    add_step(MODE_ADD, 32'h5A5A_A5A5, 1'b0, STATUS_OK, 0);
    add_step(MODE_REMOVE, 32'hDEAD_BEEF, 1'b1, STATUS_NOT_FOUND, 14);
    add_step(MODE_REMOVE, table_handle(0), 1'b0, STATUS_OK, 0);
    add_step(MODE_ABORT, '1, 1'b0, STATUS_OK, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 24);

    foreach (directed_steps[i]) begin
      send(directed_steps[i].req);
      if (directed_steps[i].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back(directed_steps[i].want);
      end
      pace();
    end
    drain();

    counted = 0;
    issued = 0;
    filling = 1'b0;
    while (counted < RANDOM_REQUESTS) begin
      if (issued % 30 == 0) filling = !filling;
      random_request(filling, r);
      send(r);
      issued++;
      if (r.mode != MODE_UNUSED) counted++;
      if (r.mode != MODE_UNUSED && counted % 100 == 0) drain();
      else pace();
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, %0d of them released handles.",
             requests_sent, results_seen, releases_seen);
    $display("Saw %0d adds to a full table and %0d removes of absent handles.",
             full_seen, missing_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
